@@ hdl/tnd_pkg.sv @@
// tnd_pkg: types, codes and helpers of the telnet record deframer and negotiator
// no dependencies; imported by tnd_negotiate, tnd_parser and the top level
`default_nettype none

package tnd_pkg;

	// record header length and the header octets that are captured
	localparam int HEADER_BYTES = 10;
	localparam int COUNT_W = $clog2(HEADER_BYTES + 1);
	localparam logic [COUNT_W-1:0] HDR_LEN = COUNT_W'(HEADER_BYTES);
	localparam logic [COUNT_W-1:0] FLAGS_POS = COUNT_W'(7);
	localparam logic [COUNT_W-1:0] OPCODE_POS = COUNT_W'(9);

	// telnet command octets
	localparam logic [7:0] C_IAC = 8'd255;
	localparam logic [7:0] C_SE = 8'd240;
	localparam logic [7:0] C_SB = 8'd250;
	localparam logic [7:0] C_WILL = 8'd251;
	localparam logic [7:0] C_DONT = 8'd254;
	localparam logic [7:0] C_EOR = 8'd239;

	// known options
	localparam logic [7:0] OPT_BINARY = 8'd0;
	localparam logic [7:0] OPT_TTYPE = 8'd24;
	localparam logic [7:0] OPT_EOR = 8'd25;
	localparam logic [7:0] OPT_ENVIRON = 8'd39;

	// negotiation verbs
	localparam logic [1:0] V_WILL = 2'd0;
	localparam logic [1:0] V_WONT = 2'd1;
	localparam logic [1:0] V_DO = 2'd2;
	localparam logic [1:0] V_DONT = 2'd3;

	// event kinds
	localparam logic [2:0] EV_BODY = 3'd0;
	localparam logic [2:0] EV_REC_END = 3'd1;
	localparam logic [2:0] EV_SB_BYTE = 3'd2;
	localparam logic [2:0] EV_SB_END = 3'd3;
	localparam logic [2:0] EV_REPLY = 3'd4;
	localparam logic [2:0] EV_IGNORED = 3'd5;

	// parser state, one-hot
	typedef enum logic [4:0] {
		PS_DATA = 5'b00001,
		PS_IAC = 5'b00010,
		PS_VERB = 5'b00100,
		PS_SB = 5'b01000,
		PS_SBIAC = 5'b10000
	} parse_state_t;

	// per-option agreement flags: bit0 binary, bit1 ttype, bit2 eor, bit3 environ
	typedef struct packed {
		logic [3:0] peer_will;
		logic [3:0] peer_do;
		logic [3:0] sent_do;
		logic [3:0] sent_will;
	} opt_sets_t;

	localparam opt_sets_t OPT_SETS_RESET = '{
		peer_will: 4'b0000,
		peer_do: 4'b0000,
		sent_do: 4'b1010,
		sent_will: 4'b0000
	};

	// one result item
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic [1:0] verb;
		logic [7:0] option;
		logic [7:0] flags;
		logic [7:0] opcode;
		logic short_rec;
	} event_t;

	function automatic logic [3:0] option_bit(input logic [7:0] o);
		logic [3:0] b;
		begin
			b = 4'b0000;
			if (o == OPT_BINARY) b = 4'b0001;
			if (o == OPT_TTYPE) b = 4'b0010;
			if (o == OPT_EOR) b = 4'b0100;
			if (o == OPT_ENVIRON) b = 4'b1000;
			return b;
		end
	endfunction

endpackage

`default_nettype wire

@@ hdl/tnd_negotiate.sv @@
// tnd_negotiate: option agreement check for one WILL/WONT/DO/DONT request
// depends on tnd_pkg
`default_nettype none

module tnd_negotiate (
	input wire logic [1:0] verb,
	input wire logic [7:0] option,
	input wire tnd_pkg::opt_sets_t sets,
	output tnd_pkg::opt_sets_t sets_next,
	output logic reply,
	output logic [1:0] reply_verb
);
	import tnd_pkg::*;

	logic [3:0] b;
	logic known;

	assign b = option_bit(option);
	assign known = |b;

	always_comb begin
		sets_next = sets;
		reply = 1'b0;
		reply_verb = V_WILL;
		case (verb)
			V_WILL: begin
				if (!known) begin
					reply = 1'b1;
					reply_verb = V_DONT;
				end else if ((sets.peer_will & b) == 4'b0000) begin
					sets_next.peer_will = sets.peer_will | b;
					if ((sets.sent_do & b) == 4'b0000) begin
						sets_next.sent_do = sets.sent_do | b;
						reply = 1'b1;
						reply_verb = V_DO;
					end
				end
			end
			V_WONT: begin
				if (known && (sets.peer_will & b) != 4'b0000) begin
					sets_next.peer_will = sets.peer_will & ~b;
					sets_next.sent_do = sets.sent_do & ~b;
					reply = 1'b1;
					reply_verb = V_DONT;
				end
			end
			V_DO: begin
				if (!known) begin
					reply = 1'b1;
					reply_verb = V_WONT;
				end else if ((sets.peer_do & b) == 4'b0000) begin
					if (option == OPT_BINARY || option == OPT_EOR) begin
						sets_next.peer_do = sets.peer_do | b;
						if ((sets.sent_will & b) == 4'b0000) begin
							sets_next.sent_will = sets.sent_will | b;
							reply = 1'b1;
							reply_verb = V_WILL;
						end
					end else begin
						// terminal type and environ are refused
						reply = 1'b1;
						reply_verb = V_WONT;
					end
				end
			end
			default: begin
				if (known && (sets.peer_do & b) != 4'b0000) begin
					sets_next.peer_do = sets.peer_do & ~b;
					sets_next.sent_will = sets.sent_will & ~b;
					reply = 1'b1;
					reply_verb = V_WONT;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/tnd_parser.sv @@
// tnd_parser: parse state, record header capture and option flags, one octet per step
// depends on tnd_pkg and tnd_negotiate
`default_nettype none

module tnd_parser (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire logic [7:0] rx_byte,
	output logic fire,
	output tnd_pkg::event_t ev
);
	import tnd_pkg::*;

	parse_state_t state_q, state_d;
	logic [1:0] held_verb_q, held_verb_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [7:0] flags_q, flags_d;
	logic [7:0] opcode_q, opcode_d;
	opt_sets_t sets_q, sets_d, sets_neg;
	logic neg_reply;
	logic [1:0] neg_verb;

	tnd_negotiate u_neg (
		.verb(held_verb_q),
		.option(rx_byte),
		.sets(sets_q),
		.sets_next(sets_neg),
		.reply(neg_reply),
		.reply_verb(neg_verb)
	);

	always_comb begin
		state_d = state_q;
		held_verb_d = held_verb_q;
		count_d = count_q;
		flags_d = flags_q;
		opcode_d = opcode_q;
		sets_d = sets_q;
		fire = 1'b0;
		ev = '0;
		case (state_q)
			PS_IAC: begin
				state_d = PS_DATA;
				if (rx_byte == C_IAC) begin
					// escaped 255 is a record octet
					if (count_q < HDR_LEN) begin
						count_d = count_q + 1'b1;
						if (count_q == FLAGS_POS) flags_d = rx_byte;
						if (count_q == OPCODE_POS) opcode_d = rx_byte;
					end else begin
						fire = 1'b1;
						ev.kind = EV_BODY;
						ev.data = rx_byte;
					end
				end else if (rx_byte inside {[C_WILL:C_DONT]}) begin
					held_verb_d = rx_byte[1:0] - C_WILL[1:0];
					state_d = PS_VERB;
				end else if (rx_byte == C_SB) begin
					state_d = PS_SB;
				end else if (rx_byte == C_EOR) begin
					fire = 1'b1;
					ev.kind = EV_REC_END;
					if (count_q < HDR_LEN) begin
						ev.short_rec = 1'b1;
					end else begin
						ev.flags = flags_q;
						ev.opcode = opcode_q;
					end
					count_d = '0;
					flags_d = '0;
					opcode_d = '0;
				end else begin
					fire = 1'b1;
					ev.kind = EV_IGNORED;
					ev.data = rx_byte;
				end
			end
			PS_VERB: begin
				state_d = PS_DATA;
				sets_d = sets_neg;
				if (neg_reply) begin
					fire = 1'b1;
					ev.kind = EV_REPLY;
					ev.verb = neg_verb;
					ev.option = rx_byte;
				end
			end
			PS_SB: begin
				if (rx_byte == C_IAC) begin
					state_d = PS_SBIAC;
				end else begin
					fire = 1'b1;
					ev.kind = EV_SB_BYTE;
					ev.data = rx_byte;
				end
			end
			PS_SBIAC: begin
				if (rx_byte == C_IAC) begin
					state_d = PS_SB;
					fire = 1'b1;
					ev.kind = EV_SB_BYTE;
					ev.data = rx_byte;
				end else if (rx_byte == C_SE) begin
					state_d = PS_DATA;
					fire = 1'b1;
					ev.kind = EV_SB_END;
				end else begin
					state_d = PS_SB;
				end
			end
			default: begin
				state_d = PS_DATA;
				if (rx_byte == C_IAC) begin
					state_d = PS_IAC;
				end else if (count_q < HDR_LEN) begin
					count_d = count_q + 1'b1;
					if (count_q == FLAGS_POS) flags_d = rx_byte;
					if (count_q == OPCODE_POS) opcode_d = rx_byte;
				end else begin
					fire = 1'b1;
					ev.kind = EV_BODY;
					ev.data = rx_byte;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PS_DATA;
			held_verb_q <= V_WILL;
			count_q <= '0;
			flags_q <= '0;
			opcode_q <= '0;
			sets_q <= OPT_SETS_RESET;
		end else if (step) begin
			state_q <= state_d;
			held_verb_q <= held_verb_d;
			count_q <= count_d;
			flags_q <= flags_d;
			opcode_q <= opcode_d;
			sets_q <= sets_d;
		end
	end

endmodule

`default_nettype wire

@@ hdl/telnet_record_deframer_negotiator.sv @@
// telnet_record_deframer_negotiator: top level, input register, parser and result register
// depends on tnd_pkg and tnd_parser
`default_nettype none

//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  rx      | rx_valid, rx_stall | rx_byte
//  ev      | ev_valid, ev_stall | event_kind, data_byte, reply_verb, option_code,
//          |                    | record_flags, record_opcode, record_short
//
//  one octet per cycle while rx_stall is low: a request sits in the input register, is
//  parsed by the single-pass logic and lands in the result register
//  when a result is made, ev_valid rises once the octet has passed the input register and the result register
//  octets that make no result (header bytes, escapes, verbs) still pass the input register
//  arst_n clears the parser to the data state, the option flags to their defaults
//  and both registers to empty; a stalled ev holds its result and, once the
//  input register is also full, rx_stall is raised

module telnet_record_deframer_negotiator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rx_valid,
	output logic rx_stall,
	input wire logic [7:0] rx_byte,
	output logic ev_valid,
	input wire logic ev_stall,
	output logic [2:0] event_kind,
	output logic [7:0] data_byte,
	output logic [1:0] reply_verb,
	output logic [7:0] option_code,
	output logic [7:0] record_flags,
	output logic [7:0] record_opcode,
	output logic record_short
);
	import tnd_pkg::*;

	// input register
	logic valid_s1;
	logic [7:0] byte_s1;

	// result register
	logic ev_valid_q;
	event_t ev_q;

	logic out_free;
	logic advance;
	logic rx_take;
	logic fire;
	event_t ev;

	// the result register can take a new result when empty or being drained
	assign out_free = !ev_valid_q || !ev_stall;
	assign advance = valid_s1 && out_free;
	assign rx_stall = valid_s1 && !out_free;
	assign rx_take = rx_valid && !rx_stall;

	tnd_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.rx_byte(byte_s1),
		.fire(fire),
		.ev(ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) begin
			byte_s1 <= rx_byte;
		end
	end

	// result register: loaded when the parsed octet moves on, else drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_q <= 1'b0;
		end else if (advance) begin
			ev_valid_q <= fire;
		end else if (!ev_stall) begin
			ev_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire) begin
			ev_q <= ev;
		end
	end

	assign ev_valid = ev_valid_q;
	assign event_kind = ev_q.kind;
	assign data_byte = ev_q.data;
	assign reply_verb = ev_q.verb;
	assign option_code = ev_q.option;
	assign record_flags = ev_q.flags;
	assign record_opcode = ev_q.opcode;
	assign record_short = ev_q.short_rec;

endmodule

`default_nettype wire
